// File: design/kpbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpbp_pkg
// Shared widths, codes and types of the key prefix bucket partition block.
// ----------------------------------------------------------------------------
package kpbp_pkg;

   localparam int unsigned BUCKET_COUNT = 64;
   localparam int unsigned BUCKET_WIDTH = $clog2(BUCKET_COUNT);
   localparam int unsigned KEY_WIDTH    = 32;
   localparam int unsigned SEL_WIDTH    = 6;
   localparam int unsigned POS_WIDTH    = 24;
   localparam int unsigned TOTAL_WIDTH  = 25;
   localparam int unsigned OP_WIDTH     = 2;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned KEY_SHIFT    = KEY_WIDTH - BUCKET_WIDTH;

   // largest histogram entry, and largest slot index
   localparam logic [TOTAL_WIDTH-1:0] MAX_TOTAL = TOTAL_WIDTH'(16777216);
   localparam logic [POS_WIDTH-1:0]   POS_TOP   = POS_WIDTH'(16777215);

   localparam logic [OP_WIDTH-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_COUNT = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_PLACE = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_QUERY = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SATURATED = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERPLACE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_ACCESS,
      ST_UPDATE
   } state_type;

endpackage

// File: design/kpbp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpbp_if
// Valid/ready channels for request and response items of the partition block.
// ----------------------------------------------------------------------------
interface kpbp_req_if;
   logic                                valid;
   logic                                ready;
   logic [kpbp_pkg::OP_WIDTH-1:0]       operation;
   logic [kpbp_pkg::KEY_WIDTH-1:0]      key_prefix;
   logic [kpbp_pkg::SEL_WIDTH-1:0]      bucket_select;

   modport source (output valid, output operation, output key_prefix,
                   output bucket_select, input ready);
   modport sink   (input valid, input operation, input key_prefix,
                   input bucket_select, output ready);
endinterface

interface kpbp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [kpbp_pkg::SEL_WIDTH-1:0]      bucket;
   logic [kpbp_pkg::POS_WIDTH-1:0]      position;
   logic [kpbp_pkg::TOTAL_WIDTH-1:0]    bucket_total;
   logic [kpbp_pkg::STATUS_WIDTH-1:0]   status;

   modport source (output valid, output bucket, output position,
                   output bucket_total, output status, input ready);
   modport sink   (input valid, input bucket, input position,
                   input bucket_total, input status, output ready);
endinterface

// File: design/key_prefix_bucket_partition.sv
`timescale 1ns / 1ps
// Clear, count, place and query go from accept to the update state, which registers the
// result once the response register is free. The first place after counting, and a query
// while counting or with an out-of-range select, first sweep the histogram memory (one entry
// read per cycle) and pass an access state. One item in work at a time; requests taken in idle.
// Reset: control and phase clear at once; histogram entries read as zero through
// per-entry valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// key_prefix_bucket_partition
// Stable counting partition of keys into buckets with histogram, prefix starts
// and per-bucket cursors held in synchronous memories.
// ----------------------------------------------------------------------------
module key_prefix_bucket_partition (
   input logic        clock,
   input logic        reset,
   kpbp_req_if.sink   req_if,
   kpbp_rsp_if.source rsp_if
);

   localparam int unsigned BC  = kpbp_pkg::BUCKET_COUNT;
   localparam int unsigned BW  = kpbp_pkg::BUCKET_WIDTH;
   localparam int unsigned CW  = BW + 1;
   localparam int unsigned PW  = kpbp_pkg::POS_WIDTH;
   localparam int unsigned TW  = kpbp_pkg::TOTAL_WIDTH;
   localparam int unsigned TW1 = TW + 1;
   localparam int unsigned SW  = kpbp_pkg::SEL_WIDTH;
   localparam int unsigned SW1 = SW + 1;
   localparam int unsigned OW  = kpbp_pkg::OP_WIDTH;
   localparam int unsigned STW = kpbp_pkg::STATUS_WIDTH;

   function automatic logic [PW-1:0] sat_pos(input logic [TW1-1:0] v);
      if (v > TW1'(kpbp_pkg::POS_TOP)) begin
         return kpbp_pkg::POS_TOP;
      end
      return v[PW-1:0];
   endfunction

   // memories
   logic [TW-1:0]    hist_mem  [BC];
   logic [PW+TW-1:0] place_mem [BC];
   logic [TW-1:0]    hist_q;
   logic [PW+TW-1:0] place_q;

   // control state
   kpbp_pkg::state_type state_ff, state_in;
   logic             phase_ff, phase_in;
   logic [BC-1:0]    hist_vld_ff, hist_vld_in;
   logic [CW-1:0]    issue_ff, issue_in;
   logic             q_vld_ff, q_vld_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // item and sweep registers
   logic [OW-1:0]    op_ff;
   logic [BW-1:0]    addr_ff;
   logic             sel_ok_ff;
   logic [BW-1:0]    q_addr_ff;
   logic [TW-1:0]    acc_ff, acc_in;
   logic [PW-1:0]    cap_ff, cap_in;
   logic [SW-1:0]    rsp_bucket_ff;
   logic [PW-1:0]    rsp_position_ff;
   logic [TW-1:0]    rsp_total_ff;
   logic [STW-1:0]   rsp_status_ff;

   // combinational
   logic             accept;
   logic             rd_en;
   logic [BW-1:0]    rd_addr;
   logic             sweep_rd;
   logic             sweep_last;
   logic             upd_go;
   logic [BW-1:0]    req_addr;
   logic             req_sel_ok;
   logic [TW-1:0]    hist_rd;
   logic [PW-1:0]    start_rd;
   logic [TW-1:0]    cursor_rd;
   logic [TW1-1:0]   acc_sum;
   logic [TW1-1:0]   place_sum;
   logic             hist_we;
   logic [TW-1:0]    hist_wdata;
   logic             place_we;
   logic [BW-1:0]    place_waddr;
   logic [PW+TW-1:0] place_wdata;
   logic [SW-1:0]    out_bucket;
   logic [PW-1:0]    out_position;
   logic [TW-1:0]    out_total;
   logic [STW-1:0]   out_status;

   assign req_addr   = (req_if.operation == kpbp_pkg::OP_QUERY)
                     ? req_if.bucket_select[BW-1:0]
                     : req_if.key_prefix[kpbp_pkg::KEY_WIDTH-1 -: BW];
   assign req_sel_ok = SW1'(req_if.bucket_select) < SW1'(BC);
   assign accept     = req_if.valid && req_if.ready;
   assign upd_go     = (state_ff == kpbp_pkg::ST_UPDATE) && (!rsp_valid_ff || rsp_if.ready);
   assign sweep_last = q_vld_ff && (q_addr_ff == BW'(BC - 1));

   assign hist_rd   = hist_vld_ff[q_addr_ff] ? hist_q : '0;
   assign start_rd  = place_q[PW+TW-1:TW];
   assign cursor_rd = place_q[TW-1:0];
   assign acc_sum   = TW1'(acc_ff) + TW1'(hist_rd);
   assign place_sum = TW1'(start_rd) + TW1'(cursor_rd);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kpbp_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               unique case (req_if.operation)
                  kpbp_pkg::OP_CLEAR, kpbp_pkg::OP_COUNT: state_in = kpbp_pkg::ST_UPDATE;
                  kpbp_pkg::OP_PLACE: begin
                     state_in = phase_ff ? kpbp_pkg::ST_UPDATE : kpbp_pkg::ST_SWEEP;
                  end
                  kpbp_pkg::OP_QUERY: begin
                     state_in = (phase_ff && req_sel_ok) ? kpbp_pkg::ST_UPDATE
                                                         : kpbp_pkg::ST_SWEEP;
                  end
               endcase
            end
         end
         kpbp_pkg::ST_SWEEP: begin
            if (sweep_last) begin
               state_in = kpbp_pkg::ST_ACCESS;
            end
         end
         kpbp_pkg::ST_ACCESS: state_in = kpbp_pkg::ST_UPDATE;
         kpbp_pkg::ST_UPDATE: begin
            if (upd_go) begin
               state_in = kpbp_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;
      sweep_rd     = 1'b0;
      unique case (state_ff)
         kpbp_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
            rd_en        = req_if.valid;
            rd_addr      = req_addr;
         end
         kpbp_pkg::ST_SWEEP: begin
            sweep_rd = issue_ff < CW'(BC);
            rd_en    = sweep_rd;
            rd_addr  = issue_ff[BW-1:0];
         end
         kpbp_pkg::ST_ACCESS: begin
            rd_en = 1'b1;
         end
         kpbp_pkg::ST_UPDATE: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // sweep and update datapath
   always_comb begin
      phase_in     = phase_ff;
      hist_vld_in  = hist_vld_ff;
      issue_in     = issue_ff;
      q_vld_in     = sweep_rd;
      acc_in       = acc_ff;
      cap_in       = cap_ff;
      hist_we      = 1'b0;
      hist_wdata   = hist_rd;
      place_we     = 1'b0;
      place_waddr  = addr_ff;
      place_wdata  = place_q;
      out_bucket   = SW'(addr_ff);
      out_position = '0;
      out_total    = '0;
      out_status   = kpbp_pkg::STATUS_OK;

      if (accept) begin
         issue_in = '0;
         acc_in   = '0;
      end
      if (sweep_rd) begin
         issue_in = issue_ff + CW'(1);
      end

      // sweep data: running prefix over the histogram
      if (state_ff == kpbp_pkg::ST_SWEEP && q_vld_ff) begin
         acc_in = (acc_sum >= TW1'(kpbp_pkg::MAX_TOTAL)) ? kpbp_pkg::MAX_TOTAL
                                                         : acc_sum[TW-1:0];
         if (op_ff == kpbp_pkg::OP_PLACE) begin
            place_we    = 1'b1;
            place_waddr = q_addr_ff;
            place_wdata = {sat_pos(TW1'(acc_ff)), TW'(0)};
            if (sweep_last) begin
               phase_in = 1'b1;
            end
         end else begin
            if (q_addr_ff == addr_ff) begin
               cap_in = sat_pos(TW1'(acc_ff));
            end
            if (sweep_last && !sel_ok_ff) begin
               cap_in = sat_pos(TW1'(acc_in));
            end
         end
      end

      if (upd_go) begin
         unique case (op_ff)
            kpbp_pkg::OP_CLEAR: begin
               out_bucket  = '0;
               hist_vld_in = '0;
               phase_in    = 1'b0;
            end
            kpbp_pkg::OP_COUNT: begin
               phase_in                = 1'b0;
               hist_we                 = 1'b1;
               hist_vld_in[addr_ff]    = 1'b1;
               if (hist_rd >= kpbp_pkg::MAX_TOTAL) begin
                  hist_wdata = kpbp_pkg::MAX_TOTAL;
                  out_status = kpbp_pkg::STATUS_SATURATED;
               end else begin
                  hist_wdata = hist_rd + TW'(1);
               end
               out_total = hist_wdata;
            end
            kpbp_pkg::OP_PLACE: begin
               out_total    = hist_rd;
               out_position = sat_pos(place_sum);
               if (cursor_rd >= hist_rd) begin
                  out_status = kpbp_pkg::STATUS_OVERPLACE;
               end else begin
                  place_we    = 1'b1;
                  place_wdata = {start_rd, cursor_rd + TW'(1)};
               end
            end
            kpbp_pkg::OP_QUERY: begin
               out_total    = sel_ok_ff ? hist_rd : '0;
               out_position = (phase_ff && sel_ok_ff) ? start_rd : cap_ff;
            end
         endcase
      end

      if (upd_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // memories: registered read, single write port each
   always_ff @(posedge clock) begin
      if (rd_en) begin
         hist_q  <= hist_mem[rd_addr];
         place_q <= place_mem[rd_addr];
      end
      if (hist_we) begin
         hist_mem[addr_ff] <= hist_wdata;
      end
      if (place_we) begin
         place_mem[place_waddr] <= place_wdata;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kpbp_pkg::ST_IDLE;
         phase_ff     <= 1'b0;
         hist_vld_ff  <= '0;
         issue_ff     <= '0;
         q_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hist_vld_ff  <= hist_vld_in;
         issue_ff     <= issue_in;
         q_vld_ff     <= q_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_if.operation;
         addr_ff   <= req_addr;
         sel_ok_ff <= req_sel_ok;
      end
      if (rd_en) begin
         q_addr_ff <= rd_addr;
      end
      acc_ff <= acc_in;
      cap_ff <= cap_in;
      if (upd_go) begin
         rsp_bucket_ff   <= out_bucket;
         rsp_position_ff <= out_position;
         rsp_total_ff    <= out_total;
         rsp_status_ff   <= out_status;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.bucket       = rsp_bucket_ff;
   assign rsp_if.position     = rsp_position_ff;
   assign rsp_if.bucket_total = rsp_total_ff;
   assign rsp_if.status       = rsp_status_ff;

endmodule

// File: design/kpbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpbp_checker
// Port-level checks of the partition block, bound to the top level.
// ----------------------------------------------------------------------------
module kpbp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [kpbp_pkg::SEL_WIDTH-1:0]      rsp_bucket,
   input logic [kpbp_pkg::POS_WIDTH-1:0]      rsp_position,
   input logic [kpbp_pkg::TOTAL_WIDTH-1:0]    rsp_bucket_total,
   input logic [kpbp_pkg::STATUS_WIDTH-1:0]   rsp_status
);

   // no response item right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one item in work at a time
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // a saturated count reports the full entry
   a_sat_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == kpbp_pkg::STATUS_SATURATED
      |-> rsp_bucket_total == kpbp_pkg::MAX_TOTAL)
      else $error("saturated count without full total");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bucket)
      && $stable(rsp_position) && $stable(rsp_bucket_total) && $stable(rsp_status))
      else $error("stalled response item changed");

endmodule

bind key_prefix_bucket_partition kpbp_checker u_kpbp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_bucket       (rsp_if.bucket),
   .rsp_position     (rsp_if.position),
   .rsp_bucket_total (rsp_if.bucket_total),
   .rsp_status       (rsp_if.status)
);

// File: tb/key_prefix_bucket_partition_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_prefix_bucket_partition_tb
// Drives count, place, query and clear items into the partition block, with
// random sender gaps and receiver stalls. A local model keeps the histogram,
// the bucket starts and the rank cursors, predicts every result, and each
// result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module key_prefix_bucket_partition_tb;

   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [kpbp_pkg::SEL_WIDTH-1:0]    bucket;
      logic [kpbp_pkg::POS_WIDTH-1:0]    position;
      logic [kpbp_pkg::TOTAL_WIDTH-1:0]  bucket_total;
      logic [kpbp_pkg::STATUS_WIDTH-1:0] status;
   } partition_result_type;

   logic clock;
   logic reset;

   kpbp_req_if req_ch ();
   kpbp_rsp_if rsp_ch ();

   key_prefix_bucket_partition DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic [kpbp_pkg::TOTAL_WIDTH-1:0] hist_count  [kpbp_pkg::BUCKET_COUNT] = '{default: '0};
   logic [kpbp_pkg::POS_WIDTH-1:0]   slot_start  [kpbp_pkg::BUCKET_COUNT] = '{default: '0};
   logic [kpbp_pkg::TOTAL_WIDTH-1:0] rank_cursor [kpbp_pkg::BUCKET_COUNT] = '{default: '0};
   logic                             placing = 1'b0;

   partition_result_type expected_results [$];
   int unsigned          items_sent  = 0;
   int unsigned          burst_left  = 1;
   int unsigned          error_count = 0;
   int unsigned          cycle_count = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // exclusive prefix sum of the histogram, saturated to the last slot
   function automatic logic [kpbp_pkg::POS_WIDTH-1:0] slots_before(input int unsigned b);
      longint unsigned sum;
      sum = 0;
      for (int unsigned i = 0; i < b && i < kpbp_pkg::BUCKET_COUNT; i++) begin
         sum += hist_count[i];
         if (sum > 64'(kpbp_pkg::MAX_TOTAL))
            sum = 64'(kpbp_pkg::MAX_TOTAL);
      end
      return (sum > 64'(kpbp_pkg::POS_TOP)) ? kpbp_pkg::POS_TOP
                                            : kpbp_pkg::POS_WIDTH'(sum);
   endfunction

   function automatic partition_result_type predict_partition(
      input logic [kpbp_pkg::OP_WIDTH-1:0]  op,
      input logic [kpbp_pkg::KEY_WIDTH-1:0] key,
      input logic [kpbp_pkg::SEL_WIDTH-1:0] sel
   );
      partition_result_type r;
      logic [kpbp_pkg::BUCKET_WIDTH-1:0] b;
      longint unsigned slot;
      r = '0;
      b = kpbp_pkg::BUCKET_WIDTH'(key >> kpbp_pkg::KEY_SHIFT);
      case (op)
         kpbp_pkg::OP_CLEAR: begin
            for (int i = 0; i < kpbp_pkg::BUCKET_COUNT; i++)
               hist_count[i] = '0;
            placing = 1'b0;
         end
         kpbp_pkg::OP_COUNT: begin
            placing  = 1'b0;
            r.bucket = b;
            if (hist_count[b] >= kpbp_pkg::MAX_TOTAL) begin
               hist_count[b] = kpbp_pkg::MAX_TOTAL;
               r.status      = kpbp_pkg::STATUS_SATURATED;
            end else begin
               hist_count[b]++;
            end
            r.bucket_total = hist_count[b];
         end
         kpbp_pkg::OP_PLACE: begin
            if (!placing) begin
               for (int i = 0; i < kpbp_pkg::BUCKET_COUNT; i++) begin
                  slot_start[i]  = slots_before(i);
                  rank_cursor[i] = '0;
               end
               placing = 1'b1;
            end
            r.bucket       = b;
            r.bucket_total = hist_count[b];
            slot = 64'(slot_start[b]) + 64'(rank_cursor[b]);
            r.position = (slot > 64'(kpbp_pkg::POS_TOP)) ? kpbp_pkg::POS_TOP
                                                         : kpbp_pkg::POS_WIDTH'(slot);
            if (rank_cursor[b] >= hist_count[b])
               r.status = kpbp_pkg::STATUS_OVERPLACE;
            else
               rank_cursor[b]++;
         end
         default: begin
            r.bucket       = sel;
            r.position     = placing ? slot_start[sel] : slots_before(sel);
            r.bucket_total = hist_count[sel];
         end
      endcase
      return r;
   endfunction

   function automatic logic [kpbp_pkg::KEY_WIDTH-1:0] key_in_bucket(
      input logic [kpbp_pkg::BUCKET_WIDTH-1:0] b
   );
      return {b, kpbp_pkg::KEY_SHIFT'($urandom)};
   endfunction

   task automatic send_item(
      input logic [kpbp_pkg::OP_WIDTH-1:0]  op,
      input logic [kpbp_pkg::KEY_WIDTH-1:0] key,
      input logic [kpbp_pkg::SEL_WIDTH-1:0] sel
   );
      int unsigned gap;
      req_ch.valid         <= 1'b1;
      req_ch.operation     <= op;
      req_ch.key_prefix    <= key;
      req_ch.bucket_select <= sel;
      do @(posedge clock); while (!req_ch.ready);
      expected_results.push_back(predict_partition(op, key, sel));
      items_sent++;
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic test_empty_histogram();
      send_item(kpbp_pkg::OP_QUERY, '0, 6'd0);
      send_item(kpbp_pkg::OP_QUERY, '0, 6'd63);
      send_item(kpbp_pkg::OP_PLACE, 32'h1234_5678, '0);
      send_item(kpbp_pkg::OP_CLEAR, 32'hFFFF_FFFF, 6'd63);
   endtask

   task automatic test_key_extremes();
      send_item(kpbp_pkg::OP_COUNT, 32'h0000_0000, '0);
      send_item(kpbp_pkg::OP_COUNT, 32'hFFFF_FFFF, '0);
      send_item(kpbp_pkg::OP_COUNT, 32'h03FF_FFFF, '0);
      send_item(kpbp_pkg::OP_COUNT, 32'h0400_0000, '0);
      send_item(kpbp_pkg::OP_COUNT, 32'hFC00_0000, '0);
      send_item(kpbp_pkg::OP_QUERY, '0, 6'd63);
      send_item(kpbp_pkg::OP_QUERY, '0, 6'd1);
      send_item(kpbp_pkg::OP_PLACE, 32'hFFFF_FFFF, '0);
      send_item(kpbp_pkg::OP_PLACE, 32'hFC00_0001, '0);
      // bucket 63 already full
      send_item(kpbp_pkg::OP_PLACE, 32'hFFFF_0000, '0);
      send_item(kpbp_pkg::OP_PLACE, 32'h0000_0001, '0);
      send_item(kpbp_pkg::OP_PLACE, 32'h03FF_FFFF, '0);
      send_item(kpbp_pkg::OP_PLACE, 32'h0400_0000, '0);
      send_item(kpbp_pkg::OP_QUERY, '0, 6'd63);
   endtask

   task automatic test_phase_changes();
      // count drops back to counting, next place rebuilds starts
      send_item(kpbp_pkg::OP_COUNT, 32'h8000_0000, '0);
      send_item(kpbp_pkg::OP_PLACE, 32'h8000_0000, '0);
      send_item(kpbp_pkg::OP_PLACE, 32'hFFFF_FFFF, '0);
      send_item(kpbp_pkg::OP_CLEAR, '0, '0);
      send_item(kpbp_pkg::OP_QUERY, '0, 6'd0);
   endtask

   task automatic test_random_batches(input int unsigned item_goal);
      logic [kpbp_pkg::KEY_WIDTH-1:0]    batch_keys [$];
      logic [kpbp_pkg::KEY_WIDTH-1:0]    tmp;
      logic [kpbp_pkg::BUCKET_WIDTH-1:0] lo;
      int unsigned                       goal;
      int unsigned                       batch_size;
      int unsigned                       spread;
      int unsigned                       j;
      goal = items_sent + item_goal;
      while (items_sent < goal) begin
         batch_keys.delete();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               send_item(kpbp_pkg::OP_WIDTH'($urandom), $urandom,
                         kpbp_pkg::SEL_WIDTH'($urandom));
         end
         if ($urandom_range(0, 9) < 7)
            send_item(kpbp_pkg::OP_CLEAR, $urandom, kpbp_pkg::SEL_WIDTH'($urandom));
         batch_size = $urandom_range(1, 24);
         spread     = $urandom_range(0, 2);
         lo         = kpbp_pkg::BUCKET_WIDTH'($urandom);
         repeat (batch_size) begin
            case (spread)
               0:       tmp = key_in_bucket(kpbp_pkg::BUCKET_WIDTH'($urandom));
               1:       tmp = key_in_bucket(lo + kpbp_pkg::BUCKET_WIDTH'($urandom_range(0, 3)));
               default: tmp = key_in_bucket($urandom_range(0, 1) ? '1 : '0);
            endcase
            batch_keys.push_back(tmp);
            send_item(kpbp_pkg::OP_COUNT, tmp, kpbp_pkg::SEL_WIDTH'($urandom));
            if ($urandom_range(0, 7) == 0)
               send_item(kpbp_pkg::OP_QUERY, $urandom, kpbp_pkg::SEL_WIDTH'($urandom));
         end
         for (int i = batch_keys.size() - 1; i > 0; i--) begin
            j             = $urandom_range(0, i);
            tmp           = batch_keys[i];
            batch_keys[i] = batch_keys[j];
            batch_keys[j] = tmp;
         end
         foreach (batch_keys[i]) begin
            send_item(kpbp_pkg::OP_PLACE, batch_keys[i], kpbp_pkg::SEL_WIDTH'($urandom));
            if ($urandom_range(0, 9) == 0)
               send_item(kpbp_pkg::OP_QUERY, $urandom, kpbp_pkg::SEL_WIDTH'($urandom));
            if ($urandom_range(0, 19) == 0)
               send_item(kpbp_pkg::OP_COUNT,
                         batch_keys[$urandom_range(0, batch_keys.size() - 1)],
                         kpbp_pkg::SEL_WIDTH'($urandom));
            if ($urandom_range(0, 14) == 0)
               send_item(kpbp_pkg::OP_PLACE, $urandom, kpbp_pkg::SEL_WIDTH'($urandom));
         end
         if ($urandom_range(0, 5) == 0)
            wait_drain();
      end
   endtask

   // result checker and receiver stall pattern
   initial begin
      partition_result_type want;
      int unsigned          stall_pct;
      int unsigned          phase_cycles;
      stall_pct    = 0;
      phase_cycles = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected item: bucket %0d position %0d total %0d status %0d",
                      rsp_ch.bucket, rsp_ch.position, rsp_ch.bucket_total, rsp_ch.status);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.bucket !== want.bucket) begin
                  $error("bucket: expected %0d, got %0d", want.bucket, rsp_ch.bucket);
                  error_count++;
               end
               if (rsp_ch.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_ch.position);
                  error_count++;
               end
               if (rsp_ch.bucket_total !== want.bucket_total) begin
                  $error("bucket_total: expected %0d, got %0d",
                         want.bucket_total, rsp_ch.bucket_total);
                  error_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  error_count++;
               end
            end
         end
         if (phase_cycles == 0) begin
            phase_cycles = $urandom_range(20, 120);
            stall_pct    = 30 * $urandom_range(0, 3);
         end
         phase_cycles--;
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.operation     <= kpbp_pkg::OP_CLEAR;
      req_ch.key_prefix    <= '0;
      req_ch.bucket_select <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_histogram();
      test_key_extremes();
      test_phase_changes();
      wait_drain();
      test_random_batches(600);

      wait_drain();
      repeat (kpbp_pkg::BUCKET_COUNT + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/kpbp_pkg.sv
design/kpbp_if.sv
design/key_prefix_bucket_partition.sv
design/kpbp_checker.sv
tb/key_prefix_bucket_partition_tb.sv
